// ===== design/ccmp_pkg.sv =====
// Shared types and codes for the cross-channel max pooling block.
`timescale 1ns / 1ps

package ccmp_pkg;

  // Fixed widths of the port fields.
  localparam int STEP_W   = 24;
  localparam int SIZE_W   = 7;
  localparam int POOL_W   = 4;
  localparam int POS_W    = 6;
  localparam int SAMPLE_W = 16;
  localparam int RESULT_W = 15;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Product of a step and a position, and the signed-free arithmetic width of the bounds.
  localparam int PROD_W = STEP_W + POS_W;
  localparam int BND_W  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_MERGE = 2'd1,
    OP_QUERY = 2'd2
  } ccmp_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_X      = 3'd0,
    REG_STEP_Y      = 3'd1,
    REG_IN_WIDTH    = 3'd2,
    REG_IN_HEIGHT   = 3'd3,
    REG_POOL_WIDTH  = 3'd4,
    REG_POOL_HEIGHT = 3'd5
  } ccmp_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_BOUNDS,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } ccmp_state_t;

  // Clipped bounds [lo, hi) of one window axis.
  typedef struct packed {
    logic             empty;
    logic [BND_W-1:0] lo;
    logic [BND_W-1:0] hi;
  } ccmp_axis_t;

endpackage

// ===== design/ccmp_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module ccmp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/cross_channel_max_pool_top.sv =====
// Cross-channel max pooling: sample store, window bounds and window scan.
`timescale 1ns / 1ps

// Usage: items enter on the input channel (in_valid, in_stall, op, pos_x, pos_y,
// sample) and results leave on the output channel (out_valid, out_stall,
// pooled_value). A transfer happens on a rising edge with valid high and stall low.
// A write stores a channel 0 sample at (pos_x, pos_y); a merge keeps the larger of
// the stored sample and a new one; a query returns the window maximum, floored at
// zero, for output position (pos_x, pos_y). Writes and merges give no result.
// A write is stored at its transfer; a merge reads the stored sample, then writes
// back the larger one. For a query, the centre products are registered at the
// transfer, then a bounds state clips the bounds, a scan state issues one store read
// per window sample, a drain state folds the last sample and a done state loads the
// output register. An empty window skips the scan and drain states. The next item is
// taken in the cycle after the result is loaded. The single read port of the store
// sets the scan rate.
// One item is worked on at a time; in_stall is high while an item is in flight.
// If the receiver stalls, a finished query waits until the output register is free.
// Reset restores the register defaults and empties the output register; the sample
// store is not cleared, so every entry must be written before use.
// Configuration must be written only while the block is idle.
module cross_channel_max_pool_top
  import ccmp_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_POOL   = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       op,
  input  logic [POS_W-1:0]      pos_x,
  input  logic [POS_W-1:0]      pos_y,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RESULT_W-1:0]   pooled_value
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int XW    = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
  localparam int LXW   = $clog2(MAX_WIDTH + 1);
  localparam int LYW   = $clog2(MAX_HEIGHT + 1);

  // Configuration registers.
  logic [STEP_W-1:0] step_x, step_y;
  logic [SIZE_W-1:0] in_width, in_height;
  logic [POOL_W-1:0] pool_width, pool_height;

  ccmp_state_t state, state_next;

  logic [SAMPLE_W-1:0] sample_r;
  logic [AW-1:0]       addr_r;
  logic [PROD_W-1:0]   prod_x, prod_y;
  logic [XW-1:0]       x_lo, x_cnt;
  logic [YW-1:0]       y_cnt;
  logic [LXW-1:0]      x_hi;
  logic [LYW-1:0]      y_hi;
  logic                pend;
  logic [RESULT_W-1:0] best;

  logic                in_store;
  logic [AW-1:0]       in_addr;
  logic [AW-1:0]       scan_addr;
  logic                scan_row_end;
  logic                scan_last;
  logic                out_free;
  ccmp_axis_t          bnd_x, bnd_y;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  // Centre is round(step * pos) half up; the window is [centre - p/2, centre + ceil(p/2))
  // clipped to [0, min(size, limit)).
  function automatic ccmp_axis_t axis_bounds(input logic [PROD_W-1:0] prod,
                                             input logic [SIZE_W-1:0] size,
                                             input logic [POOL_W-1:0] pool,
                                             input logic [BND_W-1:0]  pmax,
                                             input logic [BND_W-1:0]  limit);
    logic [PROD_W:0]    sum;
    logic [BND_W-1:0]   centre;
    logic [BND_W-1:0]   p;
    logic [BND_W-1:0]   half;
    logic [BND_W-1:0]   chalf;
    logic [BND_W-1:0]   lim;
    ccmp_axis_t         res;
    sum    = {1'b0, prod} + (PROD_W + 1)'(32768);
    centre = BND_W'(sum[PROD_W:16]);
    p      = (BND_W'(pool) > pmax) ? pmax : BND_W'(pool);
    half   = p >> 1;
    chalf  = (p + BND_W'(1)) >> 1;
    lim    = (BND_W'(size) > limit) ? limit : BND_W'(size);
    res.lo = (centre < half) ? '0 : centre - half;
    res.hi = (centre + chalf > lim) ? lim : centre + chalf;
    res.empty = (res.lo >= res.hi);
    return res;
  endfunction

  assign in_store = (BND_W'(pos_x) < BND_W'(MAX_WIDTH)) &&
                    (BND_W'(pos_y) < BND_W'(MAX_HEIGHT));
  assign in_addr  = AW'(AW'(pos_y) * AW'(MAX_WIDTH)) + AW'(pos_x);
  assign scan_addr = AW'(AW'(y_cnt) * AW'(MAX_WIDTH)) + AW'(x_cnt);
  assign scan_row_end = (LXW'(x_cnt) + LXW'(1)) == x_hi;
  assign scan_last    = scan_row_end && ((LYW'(y_cnt) + LYW'(1)) == y_hi);
  assign out_free = !out_valid || !out_stall;

  assign bnd_x = axis_bounds(prod_x, in_width, pool_width, BND_W'(MAX_POOL),
                             BND_W'(MAX_WIDTH));
  assign bnd_y = axis_bounds(prod_y, in_height, pool_height, BND_W'(MAX_POOL),
                             BND_W'(MAX_HEIGHT));

  assign in_stall = (state != ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (op == OP_MERGE && in_store) begin
            state_next = ST_MERGE;
          end else if (op == OP_QUERY) begin
            state_next = ST_BOUNDS;
          end
        end
      end
      ST_MERGE:  state_next = ST_IDLE;
      ST_BOUNDS: state_next = (bnd_x.empty || bnd_y.empty) ? ST_DONE : ST_SCAN;
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Store port controls.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_addr;
    ram_wdata = sample;
    ram_re    = 1'b0;
    ram_raddr = in_addr;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_store) begin
          ram_we = (op == OP_WRITE);
          ram_re = (op == OP_MERGE);
        end
      end
      ST_MERGE: begin
        ram_waddr = addr_r;
        ram_wdata = sample_r;
        ram_we    = $signed(sample_r) > $signed(ram_rdata);
      end
      ST_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = scan_addr;
      end
      default: begin
        ram_we = 1'b0;
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x      <= STEP_W'(65536);
      step_y      <= STEP_W'(65536);
      in_width    <= SIZE_W'(64);
      in_height   <= SIZE_W'(64);
      pool_width  <= POOL_W'(2);
      pool_height <= POOL_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_X:      step_x      <= cfg_data;
        REG_STEP_Y:      step_y      <= cfg_data;
        REG_IN_WIDTH:    in_width    <= cfg_data[SIZE_W-1:0];
        REG_IN_HEIGHT:   in_height   <= cfg_data[SIZE_W-1:0];
        REG_POOL_WIDTH:  pool_width  <= cfg_data[POOL_W-1:0];
        REG_POOL_HEIGHT: pool_height <= cfg_data[POOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == ST_SCAN);
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      sample_r <= sample;
      addr_r   <= in_addr;
      prod_x   <= PROD_W'(step_x) * PROD_W'(pos_x);
      prod_y   <= PROD_W'(step_y) * PROD_W'(pos_y);
    end
    if (state == ST_BOUNDS) begin
      // Bounds fit the counters whenever the window is not empty.
      x_lo  <= XW'(bnd_x.lo);
      x_hi  <= LXW'(bnd_x.hi);
      y_hi  <= LYW'(bnd_y.hi);
      x_cnt <= XW'(bnd_x.lo);
      y_cnt <= YW'(bnd_y.lo);
      best  <= '0;
    end else begin
      if (state == ST_SCAN) begin
        if (scan_row_end) begin
          x_cnt <= x_lo;
          y_cnt <= y_cnt + YW'(1);
        end else begin
          x_cnt <= x_cnt + XW'(1);
        end
      end
      // Negative samples never beat the zero floor.
      if (pend && !ram_rdata[SAMPLE_W-1] && (ram_rdata[RESULT_W-1:0] > best)) begin
        best <= ram_rdata[RESULT_W-1:0];
      end
    end
    if (state == ST_DONE && out_free) begin
      pooled_value <= best;
    end
  end

  ccmp_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

// ===== design/ccmp_checker.sv =====
// Port-level checks for the cross-channel max pooling block, bound to the top level.
`timescale 1ns / 1ps

module ccmp_checker
  import ccmp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [OP_W-1:0]       op,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [RESULT_W-1:0]   pooled_value
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // A result held by the receiver keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pooled_value))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  // Only a query gives a result; a query is busy in the cycle after its transfer.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_xfer && op != OP_QUERY |=> !$rose(out_valid))
    else $error("result appeared after a transfer that is not a query");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer && op == OP_QUERY |=> in_stall && !$rose(out_valid))
    else $error("query not held busy while its window is scanned");

  a_merge_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer && op == OP_MERGE |=> in_stall)
    else $error("merge write-back overlapped a new transfer");

endmodule

bind cross_channel_max_pool_top ccmp_checker u_ccmp_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the cross-channel max pooling block.
`timescale 1ns / 1ps

module testbench;
  import ccmp_pkg::*;

  localparam int STORE_SIDE   = 64;
  localparam int STORE_DEPTH  = STORE_SIDE * STORE_SIDE;
  localparam int POOL_CAP     = 8;
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_ITEMS = 850;
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
    logic [SAMPLE_W-1:0] sample;
    bit                  fixed;
    logic [RESULT_W-1:0] fixed_value;
  } pool_item_t;

  typedef struct packed {
    bit                    is_cfg;
    ccmp_reg_t             reg_id;
    logic [CFG_DATA_W-1:0] reg_data;
    pool_item_t            item;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RESULT_W-1:0] pooled_value;
  pool_item_t offered = '0;

  // Register copies used by the predictor and by the stimulus generator.
  logic [STEP_W-1:0] step_x_set = 24'h010000;
  logic [STEP_W-1:0] step_y_set = 24'h010000;
  logic [SIZE_W-1:0] in_width_set = 7'd64;
  logic [SIZE_W-1:0] in_height_set = 7'd64;
  logic [POOL_W-1:0] pool_width_set = 4'd2;
  logic [POOL_W-1:0] pool_height_set = 4'd2;

  logic signed [SAMPLE_W-1:0] channel_peak [STORE_DEPTH];
  bit filled [STORE_DEPTH];
  int filled_list[$];
  pool_item_t pending_items[$];
  logic [RESULT_W-1:0] expected_pooled[$];
  stim_row_t directed_rows[$];
  int unaccepted = 0;
  int items_sent = 0;
  int mismatches = 0;
  bit hold_wanted = 1'b0;

  cross_channel_max_pool_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(offered.op),
    .pos_x(offered.x),
    .pos_y(offered.y),
    .sample(offered.sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pooled_value(pooled_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Clipped bounds [lo, hi) of one window axis around the rounded centre.
  function automatic void axis_span(input logic [STEP_W-1:0] step, input logic [POS_W-1:0] pos,
                                    input logic [SIZE_W-1:0] size, input logic [POOL_W-1:0] pool,
                                    output int lo, output int hi);
    int p, lim, centre;
    p = (pool > POOL_CAP) ? POOL_CAP : int'(pool);
    lim = (size > STORE_SIDE) ? STORE_SIDE : int'(size);
    centre = int'((longint'(step) * longint'(pos) + 64'sd32768) >>> 16);
    lo = centre - p / 2;
    hi = centre + (p + 1) / 2;
    if (lo < 0) lo = 0;
    if (hi > lim) hi = lim;
  endfunction

  function automatic logic [RESULT_W-1:0] window_peak(logic [POS_W-1:0] ox,
                                                      logic [POS_W-1:0] oy);
    int x0, x1, y0, y1, best, r, c, v;
    axis_span(step_x_set, ox, in_width_set, pool_width_set, x0, x1);
    axis_span(step_y_set, oy, in_height_set, pool_height_set, y0, y1);
    best = 0;
    for (r = y0; r < y1; r++) begin
      for (c = x0; c < x1; c++) begin
        v = int'(channel_peak[r * STORE_SIDE + c]);
        if (v > best) best = v;
      end
    end
    return RESULT_W'(best);
  endfunction

  function automatic pool_item_t plain_item(logic [OP_W-1:0] op, logic [POS_W-1:0] x,
                                            logic [POS_W-1:0] y, logic [SAMPLE_W-1:0] s);
    pool_item_t it;
    it = '0;
    it.op = op;
    it.x = x;
    it.y = y;
    it.sample = s;
    return it;
  endfunction

  function automatic stim_row_t op_row(logic [OP_W-1:0] op, int x, int y,
                                       logic [SAMPLE_W-1:0] s);
    stim_row_t row;
    row = '0;
    row.item = plain_item(op, POS_W'(x), POS_W'(y), s);
    return row;
  endfunction

  function automatic stim_row_t query_row(int x, int y, logic [RESULT_W-1:0] value);
    stim_row_t row;
    // A query ignores its sample, so it carries all ones.
    row = op_row(OP_QUERY, x, y, 16'hFFFF);
    row.item.fixed = 1'b1;
    row.item.fixed_value = value;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(ccmp_reg_t id, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_id = id;
    row.reg_data = data;
    return row;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h8000 | 16'($urandom);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return STEP_W'($urandom);
      default: return STEP_W'($urandom_range(32'h4000, 32'h40000));
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SIZE_W'($urandom_range(65, 127));
      2: return 7'd64;
      3: return 7'd1;
      default: return SIZE_W'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [POOL_W-1:0] pick_pool();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return POOL_W'($urandom_range(9, 15));
      2: return 4'd8;
      default: return POOL_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Input position, mostly inside the clipped map so that queries find it.
  function automatic logic [POS_W-1:0] pick_in_pos(int span);
    if (span == 0 || $urandom_range(0, 4) == 0) return POS_W'($urandom_range(0, 63));
    return POS_W'($urandom_range(0, span - 1));
  endfunction

  // Output position, mostly one whose window centre lands inside the map.
  function automatic logic [POS_W-1:0] pick_out_pos(logic [STEP_W-1:0] step, int span);
    longint top;
    top = 63;
    if (step != 0) top = (longint'(span) << 16) / longint'(step);
    if (top > 63 || $urandom_range(0, 4) == 0) top = 63;
    return POS_W'($urandom_range(0, int'(top)));
  endfunction

  task automatic queue_item(pool_item_t it);
    int slot;
    pending_items.push_back(it);
    unaccepted++;
    if (it.op != OP_UNUSED) items_sent++;
    if (it.op == OP_WRITE) begin
      slot = int'(it.y) * STORE_SIDE + int'(it.x);
      if (!filled[slot]) begin
        filled[slot] = 1'b1;
        filled_list.push_back(slot);
      end
    end
  endtask

  // Waits until every item is taken and every result is back, then lets the
  // block finish a write or merge that gives no result.
  task automatic settle();
    while (unaccepted != 0 || expected_pooled.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(ccmp_reg_t id, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= id;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (id)
      REG_STEP_X:      step_x_set = data[STEP_W-1:0];
      REG_STEP_Y:      step_y_set = data[STEP_W-1:0];
      REG_IN_WIDTH:    in_width_set = data[SIZE_W-1:0];
      REG_IN_HEIGHT:   in_height_set = data[SIZE_W-1:0];
      REG_POOL_WIDTH:  pool_width_set = data[POOL_W-1:0];
      REG_POOL_HEIGHT: pool_height_set = data[POOL_W-1:0];
      default: ;
    endcase
  endtask

  initial begin : sender
    int gap_left, burst_left;
    pool_item_t next;
    gap_left = 0;
    burst_left = 0;
    forever begin
      @(posedge clk);
      // Move on only when nothing is offered or the offered item transfers now.
      if (!rst && !(in_valid && in_stall)) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next = pending_items.pop_front();
          offered <= next;
          in_valid <= 1'b1;
          burst_left--;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  initial begin : receiver
    int hold_left, mode_left, stall_pct;
    hold_left = 0;
    mode_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      if (hold_wanted && hold_left == 0) begin
        hold_left = LONG_HOLD;
        hold_wanted = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    int slot;
    logic [RESULT_W-1:0] want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        unaccepted--;
        slot = int'(offered.y) * STORE_SIDE + int'(offered.x);
        case (offered.op)
          OP_WRITE: channel_peak[slot] = offered.sample;
          OP_MERGE: begin
            if ($signed(offered.sample) > channel_peak[slot]) channel_peak[slot] = offered.sample;
          end
          OP_QUERY: begin
            expected_pooled.push_back(offered.fixed ? offered.fixed_value
                                                    : window_peak(offered.x, offered.y));
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_pooled.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: pooled_value %h with no query outstanding", $time, pooled_value);
        end else begin
          want = expected_pooled.pop_front();
          if (pooled_value !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: pooled_value expected %h, got %h", $time, want, pooled_value);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int n, phase, phase_len, roll, slot, x0, x1, y0, y1, r, c, span_x, span_y;
    logic [POS_W-1:0] qx, qy;

    // Default settings first: channel zero, merges both ways, the zero floor,
    // the unused op code.
    directed_rows.push_back(op_row(OP_WRITE, 0, 0, 16'h7FFF));
    directed_rows.push_back(query_row(0, 0, 15'h7FFF));
    directed_rows.push_back(op_row(OP_MERGE, 0, 0, 16'h8000));
    directed_rows.push_back(query_row(0, 0, 15'h7FFF));
    directed_rows.push_back(op_row(OP_WRITE, 0, 0, 16'h8000));
    directed_rows.push_back(query_row(0, 0, 15'h0000));
    directed_rows.push_back(op_row(OP_MERGE, 0, 0, 16'h0100));
    directed_rows.push_back(query_row(0, 0, 15'h0100));
    directed_rows.push_back(op_row(OP_UNUSED, 0, 0, 16'h7FFF));
    directed_rows.push_back(query_row(0, 0, 15'h0100));
    directed_rows.push_back(op_row(OP_WRITE, 1, 0, 16'h0200));
    directed_rows.push_back(op_row(OP_WRITE, 2, 0, 16'h0300));
    directed_rows.push_back(op_row(OP_WRITE, 3, 0, 16'h7FFE));
    directed_rows.push_back(query_row(1, 0, 15'h0200));
    // Oversized pool saturates to eight; a zero step pins every centre at zero.
    directed_rows.push_back(cfg_row(REG_POOL_WIDTH, 24'd15));
    directed_rows.push_back(cfg_row(REG_STEP_X, 24'd0));
    directed_rows.push_back(query_row(63, 0, 15'h7FFE));
    directed_rows.push_back(cfg_row(REG_POOL_WIDTH, 24'd0));
    directed_rows.push_back(query_row(0, 0, 15'h0000));
    directed_rows.push_back(cfg_row(REG_POOL_WIDTH, 24'd8));
    directed_rows.push_back(cfg_row(REG_IN_WIDTH, 24'd0));
    directed_rows.push_back(query_row(0, 0, 15'h0000));
    // Oversized width clips to the store; the largest step puts the centre off the map.
    directed_rows.push_back(cfg_row(REG_IN_WIDTH, 24'd127));
    directed_rows.push_back(cfg_row(REG_STEP_X, 24'hFFFFFF));
    directed_rows.push_back(query_row(1, 0, 15'h0000));
    directed_rows.push_back(query_row(0, 0, 15'h7FFE));
    directed_rows.push_back(cfg_row(REG_POOL_HEIGHT, 24'd1));
    directed_rows.push_back(cfg_row(REG_STEP_Y, 24'hFFFFFF));
    directed_rows.push_back(cfg_row(REG_IN_HEIGHT, 24'd127));
    directed_rows.push_back(query_row(0, 0, 15'h7FFE));
    directed_rows.push_back(query_row(0, 1, 15'h0000));
    directed_rows.push_back(cfg_row(REG_IN_HEIGHT, 24'd0));
    directed_rows.push_back(query_row(0, 0, 15'h0000));
    directed_rows.push_back(cfg_row(REG_IN_HEIGHT, 24'd64));
    directed_rows.push_back(cfg_row(REG_POOL_HEIGHT, 24'd0));
    directed_rows.push_back(query_row(0, 0, 15'h0000));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle();
        write_register(directed_rows[i].reg_id, directed_rows[i].reg_data);
      end else begin
        queue_item(directed_rows[i].item);
      end
    end

    phase = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      settle();
      if (phase == 0) begin
        // A tall saturated window over a zero vertical step.
        write_register(REG_STEP_X, 24'h010000);
        write_register(REG_STEP_Y, 24'd0);
        write_register(REG_IN_WIDTH, 24'd64);
        write_register(REG_IN_HEIGHT, 24'd64);
        write_register(REG_POOL_WIDTH, 24'd1);
        write_register(REG_POOL_HEIGHT, 24'd15);
      end else begin
        write_register(REG_STEP_X, pick_step());
        write_register(REG_STEP_Y, pick_step());
        write_register(REG_IN_WIDTH, pick_size());
        write_register(REG_IN_HEIGHT, pick_size());
        write_register(REG_POOL_WIDTH, pick_pool());
        write_register(REG_POOL_HEIGHT, pick_pool());
      end
      span_x = (in_width_set > STORE_SIDE) ? STORE_SIDE : int'(in_width_set);
      span_y = (in_height_set > STORE_SIDE) ? STORE_SIDE : int'(in_height_set);
      phase_len = $urandom_range(50, 110);
      // One phase runs against a long output stall so that the input backs up.
      if (phase == 1) hold_wanted = 1'b1;
      for (n = 0; n < phase_len; n++) begin
        if (phase == 3 && n == phase_len / 2) settle();
        roll = $urandom_range(0, 99);
        if (roll < 40 || filled_list.size() == 0) begin
          queue_item(plain_item(OP_WRITE, pick_in_pos(span_x), pick_in_pos(span_y),
                                pick_sample()));
        end else if (roll < 65) begin
          slot = filled_list[$urandom_range(0, filled_list.size() - 1)];
          queue_item(plain_item(OP_MERGE, POS_W'(slot % STORE_SIDE),
                                POS_W'(slot / STORE_SIDE), pick_sample()));
        end else if (roll < 97) begin
          qx = pick_out_pos(step_x_set, span_x);
          qy = pick_out_pos(step_y_set, span_y);
          // Every entry under the window must hold a sample before the query.
          axis_span(step_x_set, qx, in_width_set, pool_width_set, x0, x1);
          axis_span(step_y_set, qy, in_height_set, pool_height_set, y0, y1);
          for (r = y0; r < y1; r++) begin
            for (c = x0; c < x1; c++) begin
              if (!filled[r * STORE_SIDE + c])
                queue_item(plain_item(OP_WRITE, POS_W'(c), POS_W'(r), pick_sample()));
            end
          end
          queue_item(plain_item(OP_QUERY, qx, qy, 16'($urandom)));
        end else begin
          queue_item(plain_item(OP_UNUSED, POS_W'($urandom), POS_W'($urandom),
                                16'($urandom)));
        end
      end
      phase++;
    end

    settle();
    if (mismatches == 0 && expected_pooled.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
